/* hw/rtl/gda_pkg.sv */
// gda_pkg: payload types, calendar constants and month-length helpers
// for the gregorian date add-days block.
// Depends on nothing; used by gregorian_date_add_days.
package gda_pkg;

   localparam int YEAR_W     = 14;
   localparam int MONTH_W    = 4;
   localparam int DAY_IN_W   = 5;
   localparam int ADD_W      = 16;
   localparam int DAY_OUT_W  = 16;

   // internal widths: year may run past the output range, day sum needs a carry bit
   localparam int YEAR_WORK_W = YEAR_W + 1;
   localparam int DAY_WORK_W  = ADD_W + 1;
   localparam int REM_W       = 9;

   localparam int MONTHS_PER_YEAR = 12;
   localparam int LEAP_CYCLE      = 400;
   localparam int CENTURY         = 100;
   localparam int LEAP_STEP       = 4;
   localparam int FEB_COMMON      = 28;
   localparam int FEB_LEAP        = 29;

   localparam logic [YEAR_W-1:0]    YEAR_MAX    = '1;
   localparam logic [DAY_OUT_W-1:0] DAY_OUT_MAX = '1;

   typedef struct packed {
      logic [YEAR_W-1:0]   year_in;
      logic [MONTH_W-1:0]  month_in;
      logic [DAY_IN_W-1:0] day_in;
      logic [ADD_W-1:0]    add_days;
   } req_type;

   typedef struct packed {
      logic [YEAR_W-1:0]    year_out;
      logic [MONTH_W-1:0]   month_out;
      logic [DAY_OUT_W-1:0] day_out;
      logic                 overflow;
   } rsp_type;

   // leap test on the year remainder modulo 400
   function automatic logic is_leap(input logic [REM_W-1:0] rem);
      logic by4;
      logic by100;
      by4   = (rem % LEAP_STEP) == 0;
      by100 = (rem == REM_W'(CENTURY)) || (rem == REM_W'(2 * CENTURY))
              || (rem == REM_W'(3 * CENTURY));
      return (rem == '0) || (by4 && !by100);
   endfunction

   // length of a month 1..12; anything else reads as a long month
   function automatic logic [DAY_IN_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                      input logic              leap);
      logic [DAY_IN_W-1:0] len;
      case (month)
         4'd2:    len = leap ? DAY_IN_W'(FEB_LEAP) : DAY_IN_W'(FEB_COMMON);
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

/* hw/rtl/gda_stream_if.sv */
// gda_stream_if: valid/ready channel carrying one payload word.
// Payload type is a parameter; used for both channels of the block.
interface gda_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/gregorian_date_add_days.sv */
// gregorian_date_add_days: adds a day offset to a gregorian date and normalizes it.
// Depends on gda_pkg (types, month lengths) and gda_stream_if (channels).
//
//  channel    dir   modport  word
//  req_chan   in    sink     year_in, month_in, day_in, add_days
//  rsp_chan   out   source   year_out, month_out, day_out, overflow
//
// one word at a time: accept, reduce the year remainder modulo 400, step off whole
// months (up to about 2155) with a final fit test, then load the output register;
// a pass-through word goes from accept straight to the output load.
// all of it runs on one shared 17-bit subtractor under a four-state sequencer.
// reset (synchronous) empties the output register and returns to idle.
// a result held by a stalled sink delays only the final load; the next word
// is taken once the sequencer is back in idle.
module gregorian_date_add_days
   import gda_pkg::*;
(
   input logic             clock,
   input logic             reset,
   gda_stream_if.sink      req_chan,
   gda_stream_if.source    rsp_chan
);

   // sequencer codes
   localparam logic [1:0] ST_IDLE = 2'd0;   // waiting for a word
   localparam logic [1:0] ST_INIT = 2'd1;   // reduce year modulo 400
   localparam logic [1:0] ST_RUN  = 2'd2;   // step off whole months
   localparam logic [1:0] ST_DONE = 2'd3;   // hand result to output register

   logic [1:0]             state_ff, state_in;
   logic [YEAR_WORK_W-1:0] work_year_ff, work_year_in;
   logic [MONTH_W-1:0]     work_month_ff, work_month_in;
   logic [DAY_WORK_W-1:0]  work_day_ff, work_day_in;
   logic [YEAR_WORK_W-1:0] rem_ff, rem_in;       // year remainder, below 400 once in run
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   // shared subtractor: remainder minus 400 in init, day minus month length in run
   logic [DAY_WORK_W-1:0]  sub_a, sub_b;
   logic [DAY_WORK_W:0]    sub_diff;
   logic                   sub_borrow;
   logic                   sub_zero;

   logic [DAY_IN_W-1:0]    cur_len;
   logic                   req_take;
   logic                   out_free;
   logic                   pass_thru;
   logic [DAY_WORK_W-1:0]  start_sum;
   logic [YEAR_WORK_W-1:0] start_year;
   logic [MONTH_W-1:0]     start_month;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign cur_len = month_days(work_month_ff, is_leap(rem_ff[REM_W-1:0]));

   always_comb begin
      if (state_ff == ST_INIT) begin
         sub_a = DAY_WORK_W'(rem_ff);
         sub_b = DAY_WORK_W'(LEAP_CYCLE);
      end else begin
         sub_a = work_day_ff;
         sub_b = DAY_WORK_W'(cur_len);
      end
   end

   assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_borrow = sub_diff[DAY_WORK_W];
   assign sub_zero   = (sub_diff == '0);

   // input decode: day sum, pass-through test, month above twelve folded into the year
   assign start_sum = DAY_WORK_W'(req_chan.data.day_in) + DAY_WORK_W'(req_chan.data.add_days);
   assign pass_thru = (req_chan.data.month_in == '0) || (start_sum == '0);

   always_comb begin
      if (req_chan.data.month_in > MONTH_W'(MONTHS_PER_YEAR) && !pass_thru) begin
         start_month = req_chan.data.month_in - MONTH_W'(MONTHS_PER_YEAR);
         start_year  = YEAR_WORK_W'(req_chan.data.year_in) + 1'b1;
      end else begin
         start_month = req_chan.data.month_in;
         start_year  = YEAR_WORK_W'(req_chan.data.year_in);
      end
   end

   always_comb begin
      state_in      = state_ff;
      work_year_in  = work_year_ff;
      work_month_in = work_month_ff;
      work_day_in   = work_day_ff;
      rem_in        = rem_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               work_year_in  = start_year;
               work_month_in = start_month;
               work_day_in   = start_sum;
               rem_in        = start_year;
               state_in      = pass_thru ? ST_DONE : ST_INIT;
            end
         end
         ST_INIT: begin
            // remainder modulo 400, one subtraction a cycle
            if (sub_borrow) begin
               state_in = ST_RUN;
            end else begin
               rem_in = sub_diff[YEAR_WORK_W-1:0];
            end
         end
         ST_RUN: begin
            // day fits its month when day - len is negative or zero
            if (sub_borrow || sub_zero) begin
               state_in = ST_DONE;
            end else begin
               work_day_in = sub_diff[DAY_WORK_W-1:0];
               if (work_month_ff == MONTH_W'(MONTHS_PER_YEAR)) begin
                  work_month_in = MONTH_W'(1);
                  work_year_in  = work_year_ff + 1'b1;
                  rem_in        = (rem_ff == YEAR_WORK_W'(LEAP_CYCLE - 1)) ? '0
                                                                           : rem_ff + 1'b1;
               end else begin
                  work_month_in = work_month_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.year_out  = work_year_ff[YEAR_WORK_W-1] ? YEAR_MAX
                                                                   : work_year_ff[YEAR_W-1:0];
               rsp_data_in.overflow  = work_year_ff[YEAR_WORK_W-1];
               rsp_data_in.month_out = work_month_ff;
               rsp_data_in.day_out   = work_day_ff[DAY_WORK_W-1] ? DAY_OUT_MAX
                                                                 : work_day_ff[DAY_OUT_W-1:0];
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      work_year_ff  <= work_year_in;
      work_month_ff <= work_month_in;
      work_day_ff   <= work_day_in;
      rem_ff        <= rem_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // month stays a real month while stepping
   a_run_month: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |->
         (work_month_ff != '0 && work_month_ff <= MONTH_W'(MONTHS_PER_YEAR)))
      else $error("month out of range while stepping");

   // remainder is fully reduced once stepping starts
   a_run_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (rem_ff < YEAR_WORK_W'(LEAP_CYCLE)))
      else $error("year remainder not reduced");

   // a new result only ever comes out of the done state
   a_load_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result loaded outside done state");

   // a saturated year always reads as the maximum
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.overflow) |-> (rsp_data_ff.year_out == YEAR_MAX))
      else $error("overflow without saturated year");
`endif

endmodule

/* tb/sv/tb_top.sv */
// tb_top: self-checking bench for gregorian_date_add_days, driving dates with day
// offsets and checking each normalized date against an in-bench calendar predictor.
// Depends on gda_pkg and gda_stream_if from the rtl.
module tb_top;
   import gda_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // month numbers the predictor needs by name
   localparam int FEBRUARY  = 2;
   localparam int APRIL     = 4;
   localparam int JUNE      = 6;
   localparam int SEPTEMBER = 9;
   localparam int NOVEMBER  = 11;

   localparam int RANDOM_WORDS = 250;
   // receiver hold-off: starts once this many words went in, lasts this many cycles
   localparam int HOLD_AT     = 40;
   localparam int HOLD_CYCLES = 400;
   // after the last result: one full worst-case stepping pass and some margin
   localparam int TAIL_CYCLES = 2500;
   // room for the slowest legal word plus stalls and gaps, for each of ~275 words, 4x over
   localparam int LIMIT_CYCLES = 3000000;
   localparam int REPORT_MAX   = 10;

   logic clock;
   logic reset;

   gda_stream_if #(.payload_type(req_type)) req_if ();
   gda_stream_if #(.payload_type(rsp_type)) rsp_if ();

   gregorian_date_add_days uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   req_type words_to_send[$];   // stimulus not yet offered
   rsp_type dates_due[$];       // predicted results, oldest first
   int unsigned words_in;       // words accepted by the block
   int unsigned bad_words;      // mismatches and unexpected results
   int unsigned send_gap;
   int unsigned stall_left;
   int unsigned hold_left;
   logic        hold_armed;
   int unsigned cycles_run;

   // -------------------------------------------------------------------------
   // calendar predictor: add the offset, then step whole months off the day
   // -------------------------------------------------------------------------
   function automatic rsp_type normalized_date(input req_type w);
      int unsigned yr;
      int unsigned mon;
      int unsigned dsum;
      int unsigned len;
      logic        leap;
      rsp_type     r;
      yr   = w.year_in;
      mon  = w.month_in;
      dsum = int'(w.day_in) + int'(w.add_days);
      // no month or nothing to count: date goes through, day sum saturated
      if (mon == 0 || dsum == 0) begin
         r.year_out  = YEAR_W'(yr);
         r.month_out = MONTH_W'(mon);
         r.day_out   = (dsum > DAY_OUT_MAX) ? DAY_OUT_MAX : DAY_OUT_W'(dsum);
         r.overflow  = 1'b0;
         return r;
      end
      // months 13..15 fold into the following year first
      if (mon > MONTHS_PER_YEAR) begin
         mon = mon - MONTHS_PER_YEAR;
         yr  = yr + 1;
      end
      forever begin
         leap = (yr % LEAP_CYCLE == 0) || ((yr % CENTURY != 0) && (yr % LEAP_STEP == 0));
         case (mon)
            FEBRUARY:                          len = leap ? FEB_LEAP : FEB_COMMON;
            APRIL, JUNE, SEPTEMBER, NOVEMBER:  len = 30;
            default:                           len = 31;
         endcase
         if (dsum <= len) break;
         dsum = dsum - len;
         mon  = mon + 1;
         if (mon > MONTHS_PER_YEAR) begin
            mon = 1;
            yr  = yr + 1;
         end
      end
      // year is tracked unbounded, clipped only on the way out
      r.overflow  = (yr > YEAR_MAX);
      r.year_out  = r.overflow ? YEAR_MAX : YEAR_W'(yr);
      r.month_out = MONTH_W'(mon);
      r.day_out   = DAY_OUT_W'(dsum);
      return r;
   endfunction

   // gap length shared by both sides: mostly none or short, a few long;
   // every fourth block of 32 words runs with no gaps at all
   function automatic int unsigned draw_gap();
      int unsigned pick;
      if ((words_in / 32) % 4 == 3) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic queue_date(input int y, input int m, input int d, input int a);
      req_type w;
      w.year_in  = YEAR_W'(y);
      w.month_in = MONTH_W'(m);
      w.day_in   = DAY_IN_W'(d);
      w.add_days = ADD_W'(a);
      words_to_send.push_back(w);
   endtask

   // random date word; offsets kept mostly small since every month stepped adds to the run
   function automatic req_type random_date();
      req_type     w;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 85) w.year_in = YEAR_W'($urandom_range(0, 9999));
      else           w.year_in = YEAR_W'($urandom_range(9999, 16383));
      pick = $urandom_range(0, 99);
      if (pick < 84)      w.month_in = MONTH_W'($urandom_range(1, 12));
      else if (pick < 90) w.month_in = '0;
      else                w.month_in = MONTH_W'($urandom_range(13, 15));
      w.day_in = DAY_IN_W'($urandom_range(0, 31));
      pick = $urandom_range(0, 99);
      if (pick < 60)      w.add_days = ADD_W'($urandom_range(0, 40));
      else if (pick < 85) w.add_days = ADD_W'($urandom_range(0, 800));
      else if (pick < 97) w.add_days = ADD_W'($urandom_range(0, 8000));
      else                w.add_days = ADD_W'($urandom_range(0, 65535));
      return w;
   endfunction

   // -------------------------------------------------------------------------
   // clock
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // driver: offers queued words, holds valid until taken, random gaps between
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.data  <= '0;
         send_gap     <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (send_gap != 0) begin
            send_gap     <= send_gap - 1;
            req_if.valid <= 1'b0;
         end else if (words_to_send.size() != 0) begin
            req_if.data  <= words_to_send.pop_front();
            req_if.valid <= 1'b1;
            send_gap     <= draw_gap();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // receiver ready: one long hold-off while the sender keeps offering, so the
   // block ends up with a result parked and its input stalled; otherwise
   // random stalls after each result word
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
         hold_left    <= 0;
         hold_armed   <= 1'b1;
      end else if (hold_armed && words_in == HOLD_AT) begin
         hold_armed   <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         int unsigned gap;
         gap = draw_gap();
         stall_left   <= gap;
         rsp_if.ready <= (gap == 0);
      end else if (stall_left != 0) begin
         stall_left   <= stall_left - 1;
         rsp_if.ready <= (stall_left == 1);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // monitor: predicts on each accepted input word, checks each result word
   // against the oldest prediction; both in one process so the order is fixed
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (reset) begin
         words_in  <= 0;
         bad_words <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            dates_due.push_back(normalized_date(req_if.data));
            words_in <= words_in + 1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (dates_due.size() == 0) begin
               if (bad_words < REPORT_MAX)
                  $display("unexpected result word: year %0d month %0d day %0d ovf %0b",
                           got.year_out, got.month_out, got.day_out, got.overflow);
               bad_words <= bad_words + 1;
            end else begin
               want = dates_due.pop_front();
               if (got.year_out !== want.year_out || got.month_out !== want.month_out
                   || got.day_out !== want.day_out || got.overflow !== want.overflow) begin
                  if (bad_words < REPORT_MAX)
                     $display({"mismatch: exp year %0d month %0d day %0d ovf %0b, ",
                               "got year %0d month %0d day %0d ovf %0b"},
                              want.year_out, want.month_out, want.day_out, want.overflow,
                              got.year_out, got.month_out, got.day_out, got.overflow);
                  bad_words <= bad_words + 1;
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // timeout
   // -------------------------------------------------------------------------
   initial begin
      cycles_run = 0;
      while (cycles_run < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("FAILURE");
      $finish;
   end

   // -------------------------------------------------------------------------
   // stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin
      reset = 1'b1;

      // directed: plain and boundary dates
      queue_date(2023, 1, 15, 0);         // already fits its month
      queue_date(2023, 12, 31, 1);        // new year
      queue_date(2024, 2, 28, 1);         // leap february
      queue_date(2023, 2, 28, 1);         // common february
      queue_date(1900, 2, 28, 1);         // century, not leap
      queue_date(2000, 2, 28, 1);         // 400-year rule, leap
      queue_date(0, 2, 29, 0);            // year zero counts as leap
      queue_date(2100, 2, 29, 0);         // day too large for a common february
      queue_date(2023, 4, 31, 0);         // day 31 in a 30-day month
      // pass-through: no month, or zero day sum
      queue_date(2000, 0, 5, 10);
      queue_date(2000, 3, 0, 0);
      queue_date(2000, 0, 31, 65535);     // day sum saturates
      queue_date(16383, 0, 31, 65535);
      queue_date(2000, 5, 0, 1);          // day zero but offset given: stepped
      // months past december fold into the next year
      queue_date(2000, 13, 10, 0);
      queue_date(2000, 15, 31, 65535);
      // year saturation
      queue_date(16383, 12, 31, 1);
      queue_date(16383, 15, 1, 0);
      // long offsets
      queue_date(0, 1, 1, 65535);
      queue_date(9999, 12, 31, 65535);
      queue_date(8191, 7, 16, 32768);

      repeat (RANDOM_WORDS) words_to_send.push_back(random_date());

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // all words handed over, then all results in, then a quiet tail
      while (words_to_send.size() != 0 || req_if.valid !== 1'b0) @(posedge clock);
      while (dates_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (bad_words == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/gda_pkg.sv
hw/rtl/gda_stream_if.sv
hw/rtl/gregorian_date_add_days.sv
tb/sv/tb_top.sv
